[rtl/q16_16_fixed_point_alu_top_macros.svh]
// ---------------------------------------------------------------------------
// Q16.16 ALU assertion macros
// Shared concurrent assertion forms for the fixed-point ALU.
// ---------------------------------------------------------------------------
`ifndef Q16_16_FIXED_POINT_ALU_TOP_MACROS_SVH
`define Q16_16_FIXED_POINT_ALU_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define QALU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define QALU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/qalu_pkg.sv]
// ---------------------------------------------------------------------------
// Q16.16 ALU package
// Command codes for the ALU, and widths shared with its channel interfaces.
// ---------------------------------------------------------------------------
`default_nettype none
package qalu_pkg;

  typedef enum logic [2:0] {
    CMD_F2X = 3'd0,
    CMD_X2F = 3'd1,
    CMD_I2X = 3'd2,
    CMD_X2I = 3'd3,
    CMD_MUL = 3'd4,
    CMD_DIV = 3'd5
  } alu_cmd_t;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned WORD_W = 32;

endpackage
`default_nettype wire

[rtl/qalu_in_if.sv]
// ---------------------------------------------------------------------------
// Q16.16 ALU input channel
// Valid/ready channel carrying a command and two raw operands.
// ---------------------------------------------------------------------------
`default_nettype none
interface qalu_in_if;
  logic                         valid;
  logic                         ready;
  logic [qalu_pkg::CMD_W-1:0]   cmd;
  logic [qalu_pkg::WORD_W-1:0]  operand_a;
  logic [qalu_pkg::WORD_W-1:0]  operand_b;

  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

[rtl/qalu_out_if.sv]
// ---------------------------------------------------------------------------
// Q16.16 ALU result channel
// Valid/ready channel carrying the result word and its flags.
// ---------------------------------------------------------------------------
`default_nettype none
interface qalu_out_if;
  logic                         valid;
  logic                         ready;
  logic [qalu_pkg::WORD_W-1:0]  result_bits;
  logic                         saturated;
  logic                         divide_by_zero;

  modport source (output valid, result_bits, saturated, divide_by_zero, input ready);
  modport sink   (input valid, result_bits, saturated, divide_by_zero, output ready);
endinterface
`default_nettype wire

[rtl/q16_16_fixed_point_alu_top.sv]
// ---------------------------------------------------------------------------
// Q16.16 fixed-point ALU
// Conversions between IEEE single, Q and int32, Q multiply and Q divide.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : sink of cmd, operand_a, operand_b; a transfer takes one command.
//   out_ch : source of result_bits, saturated, divide_by_zero; one result
//            per command, in command order.
//   Every command runs through the same pipeline of
//   ceil((32+FRAC_BITS)/DIV_STEPS) + 3 register stages (15 stages at the
//   defaults): an input register, a prepare stage, the divider stages and a
//   final stage. The depth is set by the restoring divider, DIV_STEPS
//   quotient bits per stage.
//   Throughput is one command per cycle for every mix of commands while out_ch.ready stays high.
//   Reset clears all stage valid bits; in_ch.ready is high out of reset.
//   When out_ch.ready is low with a result waiting, the whole pipeline
//   holds and in_ch.ready drops; nothing is lost or repeated. A new
//   command is taken in the same cycle the waiting result transfers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "q16_16_fixed_point_alu_top_macros.svh"
module q16_16_fixed_point_alu_top #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIV_STEPS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qalu_in_if.sink   in_ch,
  qalu_out_if.source out_ch
);
  import qalu_pkg::*;

  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned DS  = (NW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned NP  = DS * DIV_STEPS;
  localparam int unsigned NST = DS + 3;
  localparam int unsigned LST = NST - 1;
  localparam logic signed [31:0] LIM = 32'sd1 <<< (31 - FRAC_BITS);

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       res;
    logic              sat;
    logic              dbz;
    logic              qneg;
    logic [32:0]       rem;
    logic [NP-1:0]     quo;
    logic [31:0]       dvs;
    logic signed [63:0] prod;
  } stage_t;

  stage_t           stg_r   [NST];
  stage_t           stg_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic             adv;

  assign adv         = !vld_r[LST] || out_ch.ready;
  assign in_ch.ready = adv;

  // input register
  always_comb begin
    stg_nxt[0]          = stg_r[0];
    stg_nxt[0].cmd      = in_ch.cmd;
    stg_nxt[0].res      = in_ch.operand_a;
    stg_nxt[0].dvs      = in_ch.operand_b;
  end

  // prepare stage: conversions, product, divider setup
  logic               f_neg;
  logic [7:0]         f_ex;
  logic [23:0]        f_m;
  logic signed [9:0]  f_s;
  logic [40:0]        f_mag;
  logic [31:0]        x_mag;
  logic [4:0]         x_p;
  logic [23:0]        x_mant;
  logic [31:0]        x_rem;
  logic [31:0]        x_half;
  logic [3:0]         x_sh;
  logic [7:0]         x_ex;
  logic [31:0]        a_mag;
  logic [31:0]        b_mag;

  always_comb begin
    stage_t s;
    logic [31:0] a;
    logic [31:0] b;
    s = stg_r[0];
    a = stg_r[0].res;
    b = stg_r[0].dvs;
    f_neg  = a[31];
    f_ex   = a[30:23];
    f_m    = (f_ex == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    f_s    = $signed({2'b00, ((f_ex == 8'd0) ? 8'd1 : f_ex)}) - 10'sd150
             + 10'(FRAC_BITS);
    f_mag  = '0;
    x_mag  = a[31] ? (32'd0 - a) : a;
    x_p    = '0;
    x_mant = '0;
    x_rem  = '0;
    x_half = '0;
    x_sh   = '0;
    x_ex   = '0;
    a_mag  = a[31] ? (32'd0 - a) : a;
    b_mag  = b[31] ? (32'd0 - b) : b;
    s.res  = '0;
    s.sat  = 1'b0;
    s.dbz  = 1'b0;
    s.qneg = a[31] ^ b[31];
    s.rem  = '0;
    s.quo  = NP'({{(NP-32){1'b0}}, a_mag} << FRAC_BITS);
    s.dvs  = b_mag;
    s.prod = $signed(a) * $signed(b);
    for (int i = 0; i < 32; i++) begin
      if (x_mag[i]) x_p = 5'(i);
    end
    case (s.cmd)
      CMD_F2X: begin
        if (f_s >= 10'sd9) f_mag = 41'd1 << 40;
        else if (f_s >= 10'sd0) f_mag = 41'(f_m) << f_s[3:0];
        else if (f_s > -10'sd40) f_mag = 41'(f_m) >> 6'(-f_s);
        else f_mag = '0;
        if (f_ex == 8'hFF) begin
          if (a[22:0] != 23'd0) s.res = '0;
          else begin
            s.sat = 1'b1;
            s.res = f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
        end else if (!f_neg) begin
          if (f_mag > 41'h7FFF_FFFF) begin
            s.sat = 1'b1;
            s.res = 32'h7FFF_FFFF;
          end else s.res = f_mag[31:0];
        end else begin
          if (f_mag >= 41'h8000_0000) begin
            s.sat = (f_mag > 41'h8000_0000);
            s.res = 32'h8000_0000;
          end else s.res = 32'd0 - f_mag[31:0];
        end
      end
      CMD_X2F: begin
        if (x_mag != 32'd0) begin
          x_ex = 8'(8'd127 + 8'(x_p) - 8'(FRAC_BITS));
          if (x_p <= 5'd23) x_mant = 24'(x_mag << (5'd23 - x_p));
          else begin
            x_sh   = 4'(x_p - 5'd23);
            x_rem  = x_mag & ((32'd1 << x_sh) - 32'd1);
            x_half = 32'd1 << (x_sh - 4'd1);
            x_mant = 24'(x_mag >> x_sh);
            if (x_rem > x_half || (x_rem == x_half && x_mant[0])) begin
              if (x_mant == 24'hFF_FFFF) begin
                x_mant = 24'h80_0000;
                x_ex   = x_ex + 8'd1;
              end else x_mant = x_mant + 24'd1;
            end
          end
          s.res = {a[31], x_ex, x_mant[22:0]};
        end
      end
      CMD_I2X: begin
        if ($signed(a) >= LIM) begin
          s.res = 32'h7FFF_FFFF;
          s.sat = 1'b1;
        end else if ($signed(a) <= -LIM) begin
          s.res = 32'h8000_0000;
          s.sat = ($signed(a) < -LIM);
        end else s.res = a << FRAC_BITS;
      end
      CMD_X2I: s.res = 32'($signed(a) >>> FRAC_BITS);
      CMD_DIV: s.dbz = (b == 32'd0);
      default: s.res = '0;
    endcase
    stg_nxt[1] = s;
  end

  // divider stages
  for (genvar g = 1; g <= DS; g++) begin : g_div
    always_comb begin
      stage_t s;
      s = stg_r[g];
      for (int k = 0; k < DIV_STEPS; k++) begin
        s.rem = {s.rem[31:0], s.quo[NP-1]};
        s.quo = {s.quo[NP-2:0], 1'b0};
        if (s.rem >= {1'b0, s.dvs}) begin
          s.rem    = s.rem - {1'b0, s.dvs};
          s.quo[0] = 1'b1;
        end
      end
      stg_nxt[g+1] = s;
    end
  end

  // final stage: multiply saturation, quotient sign
  always_comb begin
    stage_t s;
    logic signed [63:0] p;
    s = stg_r[DS+1];
    p = s.prod >>> FRAC_BITS;
    case (s.cmd)
      CMD_MUL: begin
        if (p > 64'sh7FFF_FFFF) begin
          s.res = 32'h7FFF_FFFF;
          s.sat = 1'b1;
        end else if (p < -64'sh8000_0000) begin
          s.res = 32'h8000_0000;
          s.sat = 1'b1;
        end else s.res = p[31:0];
      end
      CMD_DIV: begin
        if (s.dbz) s.res = '0;
        else s.res = s.qneg ? (32'd0 - s.quo[31:0]) : s.quo[31:0];
      end
      default: s.res = s.res;
    endcase
    stg_nxt[LST] = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) stg_r[i] <= stg_nxt[i];
    end
  end

  assign out_ch.valid          = vld_r[LST];
  assign out_ch.result_bits    = stg_r[LST].res;
  assign out_ch.saturated      = stg_r[LST].sat;
  assign out_ch.divide_by_zero = stg_r[LST].dbz;

  `QALU_ASSERT_NXT(a_in_lands, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0], "accepted command not captured")
  `QALU_ASSERT_NOW(a_dbz_zero, clk, rst_n, out_ch.valid && out_ch.divide_by_zero, out_ch.result_bits == 32'd0 && !out_ch.saturated, "zero divisor result not cleared")
  `QALU_ASSERT_NOW(a_dbz_div, clk, rst_n, vld_r[LST] && stg_r[LST].dbz, stg_r[LST].cmd == CMD_DIV, "divide flag on non-divide")
  `QALU_ASSERT_NXT(a_hold, clk, rst_n, vld_r[LST] && !out_ch.ready, vld_r[LST], "waiting result dropped")

endmodule
`default_nettype wire

[tb/sv/tb_q16_16_fixed_point_alu_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Q16.16 fixed-point ALU testbench
// Drives directed and random commands through the input channel with random
// gaps and back-pressure, predicts every result in place and checks the
// result channel transfer by transfer, in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_q16_16_fixed_point_alu_top;
  import qalu_pkg::*;

  localparam int          FRAC     = 16;
  localparam logic [2:0]  CMD_RSV6 = 3'd6;
  localparam logic [2:0]  CMD_RSV7 = 3'd7;
  localparam int          N_RANDOM = 700;
  localparam int          MAX_CYC  = 200000;
  localparam int          DRAIN    = 40;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [31:0] res;
    logic        sat;
    logic        dbz;
  } alu_res_t;

  logic clk;
  logic rst_n;

  qalu_in_if  in_ch();
  qalu_out_if out_ch();

  q16_16_fixed_point_alu_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       cycle_cnt;
  int       mismatches;
  int       n_sent;
  int       n_checked;
  int       n_sat;
  int       n_dbz;
  bit       in_xfer;

  function automatic alu_res_t float_to_q(input logic [31:0] bits);
    alu_res_t    r;
    logic [63:0] m;
    logic [63:0] mag;
    int          ex;
    int          sh;
    r = '0;
    ex = int'(bits[30:23]);
    if (ex == 255) begin
      if (bits[22:0] != 0) return r;
      r.sat = 1'b1;
      r.res = bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return r;
    end
    if (ex == 0) begin
      m = {41'd0, bits[22:0]};
      ex = 1;
    end else begin
      m = {40'd0, 1'b1, bits[22:0]};
    end
    if (m == 0) return r;
    sh = ex - 150 + FRAC;
    if (sh >= 9) mag = 64'd1 << 40;
    else if (sh >= 0) mag = m << sh;
    else if (sh > -40) mag = m >> (-sh);
    else mag = 0;
    if (!bits[31]) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.res = 32'h7FFF_FFFF;
      end else begin
        r.res = mag[31:0];
      end
    end else if (mag >= 64'h8000_0000) begin
      r.sat = (mag > 64'h8000_0000);
      r.res = 32'h8000_0000;
    end else begin
      r.res = 32'd0 - mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] q_to_float(input logic [31:0] bits);
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    int          p;
    int          sh;
    mag = bits[31] ? (32'd0 - bits) : bits;
    if (mag == 0) return 32'd0;
    p = 31;
    while (mag[p] == 1'b0) p--;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      sh = p - 23;
      rem = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {bits[31], 8'(127 + p - FRAC), mant[22:0]};
  endfunction

  function automatic alu_res_t alu_predict(input alu_op_t op);
    alu_res_t    r;
    longint      a;
    longint      b;
    longint      lim;
    longint      prod;
    r = '0;
    a = longint'($signed(op.a));
    b = longint'($signed(op.b));
    lim = longint'(1) << (31 - FRAC);
    case (op.cmd)
      CMD_F2X: r = float_to_q(op.a);
      CMD_X2F: r.res = q_to_float(op.a);
      CMD_I2X: begin
        if (a >= lim) begin
          r.res = 32'h7FFF_FFFF;
          r.sat = 1'b1;
        end else if (a <= -lim) begin
          r.res = 32'h8000_0000;
          r.sat = (a < -lim);
        end else begin
          r.res = 32'(a << FRAC);
        end
      end
      CMD_X2I: r.res = 32'(a >>> FRAC);
      CMD_MUL: begin
        prod = (a * b) >>> FRAC;
        if (prod > 64'sd2147483647) begin
          prod = 64'sd2147483647;
          r.sat = 1'b1;
        end else if (prod < -64'sd2147483648) begin
          prod = -64'sd2147483648;
          r.sat = 1'b1;
        end
        r.res = 32'(prod);
      end
      CMD_DIV: begin
        if (b == 0) r.dbz = 1'b1;
        else r.res = 32'((a * (longint'(1) << FRAC)) / b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word(input logic [2:0] cmd);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 80000)) - 40000);
      2: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 160)), 23'($urandom)};
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000) << $urandom_range(0, 15);
      4: return (cmd == CMD_DIV && $urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      default: return {$urandom_range(0, 1) == 1, 31'($urandom) >> $urandom_range(0, 31)};
    endcase
  endfunction

  task automatic add_op(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b);
    alu_op_t op;
    op.cmd = cmd;
    op.a   = a;
    op.b   = b;
    pending_ops.push_back(op);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYC) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input side: predict on each accepted transfer
  always @(posedge clk) begin
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    if (in_xfer) begin
      expected_results.push_back(alu_predict({in_ch.cmd, in_ch.operand_a, in_ch.operand_b}));
      n_sent++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    alu_res_t got;
    alu_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.result_bits, out_ch.saturated, out_ch.divide_by_zero};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h sat %b dbz %b", got.res, got.sat, got.dbz);
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        n_sat += exp_r.sat;
        n_dbz += exp_r.dbz;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp %h/%b/%b got %h/%b/%b", n_checked,
                     exp_r.res, exp_r.sat, exp_r.dbz, got.res, got.sat, got.dbz);
        end
      end
    end
  end

  // driver: advance on transfer, idle at random outside the steady stretch
  always @(negedge clk) begin
    bit      idle;
    alu_op_t op;
    idle = (cycle_cnt < 500 || cycle_cnt > 700) && ($urandom_range(0, 99) < 15);
    if (!rst_n || (in_ch.valid && !in_xfer)) begin
    end else if (pending_ops.size() != 0 && !idle) begin
      op = pending_ops.pop_front();
      in_ch.valid     <= 1'b1;
      in_ch.cmd       <= op.cmd;
      in_ch.operand_a <= op.a;
      in_ch.operand_b <= op.b;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver: long hold-off early in the run, no stalls in the steady stretch, random stalls elsewhere
  always @(negedge clk) begin
    if (cycle_cnt >= 200 && cycle_cnt < 400)
      out_ch.ready <= 1'b0;
    else if (cycle_cnt >= 500 && cycle_cnt <= 700)
      out_ch.ready <= 1'b1;
    else
      out_ch.ready <= ($urandom_range(0, 99) >= 15);
  end

  initial begin
    int      k;
    logic [2:0] c;
    cycle_cnt = 0;
    mismatches = 0;
    n_sent = 0;
    n_checked = 0;
    n_sat = 0;
    n_dbz = 0;
    in_xfer = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;

    // float to fixed: zeros, limits, infinities, NaN, subnormal, huge
    add_op(CMD_F2X, 32'h0000_0000, 32'hFFFF_FFFF);
    add_op(CMD_F2X, 32'h8000_0000, 32'h0);
    add_op(CMD_F2X, 32'h4700_0000, 32'h0);
    add_op(CMD_F2X, 32'hC700_0000, 32'h0);
    add_op(CMD_F2X, 32'h7F80_0000, 32'h0);
    add_op(CMD_F2X, 32'hFF80_0000, 32'h0);
    add_op(CMD_F2X, 32'h7FC0_0001, 32'h0);
    add_op(CMD_F2X, 32'h0000_0001, 32'h0);
    add_op(CMD_F2X, 32'hFF7F_FFFF, 32'h0);
    add_op(CMD_F2X, 32'hC6FF_FFFF, 32'h0);
    // fixed to float: zero, extremes, rounding ties
    add_op(CMD_X2F, 32'h0000_0000, 32'h0);
    add_op(CMD_X2F, 32'h8000_0000, 32'h0);
    add_op(CMD_X2F, 32'h7FFF_FFFF, 32'h0);
    add_op(CMD_X2F, 32'h0100_0003, 32'h0);
    add_op(CMD_X2F, 32'hFFFF_FFFF, 32'h0);
    // int to fixed and back
    add_op(CMD_I2X, 32'd32768, 32'h0);
    add_op(CMD_I2X, 32'd32767, 32'h0);
    add_op(CMD_I2X, -32'sd32768, 32'h0);
    add_op(CMD_I2X, -32'sd32769, 32'h0);
    add_op(CMD_X2I, 32'h8000_0000, 32'h0);
    add_op(CMD_X2I, 32'hFFFF_FFFF, 32'h0);
    // multiply and divide extremes, zero divisor, unused commands
    add_op(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    add_op(CMD_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
    add_op(CMD_DIV, 32'h1234_5678, 32'h0);
    add_op(CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    add_op(CMD_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
    add_op(CMD_RSV6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(CMD_RSV7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (k = 0; k < N_RANDOM; k++) begin
      c = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      add_op(c, rand_word(c), rand_word(c));
    end

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (DRAIN) @(posedge clk);

    $display("%0d commands sent, %0d results checked (%0d saturated, %0d zero divisor)",
             n_sent, n_checked, n_sat, n_dbz);
    $display("all six operations plus unused codes, with gaps, stalls and a long hold-off");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/qalu_pkg.sv
rtl/qalu_in_if.sv
rtl/qalu_out_if.sv
rtl/q16_16_fixed_point_alu_top.sv
tb/sv/tb_q16_16_fixed_point_alu_top.sv
